[rtl/nearest_centroid_confusion_counter_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-centroid confusion counter
// Shared concurrent assertion forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_CONFUSION_COUNTER_DEFINES_SVH
`define NEAREST_CENTROID_CONFUSION_COUNTER_DEFINES_SVH

// same-cycle implication
`define NCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ncc_pkg.sv]
// ----------------------------------------------------------------------------
// ncc_pkg
// Function codes and the control bundle handed along the classifier chain.
// ----------------------------------------------------------------------------
package ncc_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_CLASSIFY = 2'd0;
  localparam func_t FUNC_CLEAR    = 2'd1;
  localparam func_t FUNC_READ     = 2'd2;

  typedef struct packed {
    logic  valid;
    func_t func;
  } ncc_ctl_t;

endpackage

[rtl/ncc_ram.sv]
// ----------------------------------------------------------------------------
// ncc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ncc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/ncc_cell.sv]
// ----------------------------------------------------------------------------
// ncc_cell
// One classifier cell: squared distance to its own centroid, keeps the best.
// ----------------------------------------------------------------------------
module ncc_cell #(
  parameter int SAMPLE_BITS = 12,
  parameter int CLASS_BITS  = 3,
  parameter int DIST_BITS   = 26,
  parameter int CELL_IDX    = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [3*SAMPLE_BITS-1:0] centroid,
  input  ncc_pkg::ncc_ctl_t        ctl_in,
  input  logic [SAMPLE_BITS-1:0]   x_in,
  input  logic [SAMPLE_BITS-1:0]   y_in,
  input  logic [SAMPLE_BITS-1:0]   z_in,
  input  logic [CLASS_BITS-1:0]    row_in,
  input  logic [CLASS_BITS-1:0]    col_in,
  input  logic [DIST_BITS-1:0]     best_d_in,
  input  logic [CLASS_BITS-1:0]    best_idx_in,
  input  logic                     ready_in,
  output logic                     ready_out,
  output ncc_pkg::ncc_ctl_t        ctl_out,
  output logic [SAMPLE_BITS-1:0]   x_out,
  output logic [SAMPLE_BITS-1:0]   y_out,
  output logic [SAMPLE_BITS-1:0]   z_out,
  output logic [CLASS_BITS-1:0]    row_out,
  output logic [CLASS_BITS-1:0]    col_out,
  output logic [DIST_BITS-1:0]     best_d_out,
  output logic [CLASS_BITS-1:0]    best_idx_out
);

  logic                       v_r;
  ncc_pkg::func_t             func_r;
  logic [SAMPLE_BITS-1:0]     x_r, y_r, z_r;
  logic [CLASS_BITS-1:0]      row_r, col_r, best_idx_r;
  logic [DIST_BITS-1:0]       best_d_r;

  logic [SAMPLE_BITS-1:0]     cx, cy, cz;
  logic [SAMPLE_BITS-1:0]     dx, dy, dz;
  logic [2*SAMPLE_BITS-1:0]   sqx, sqy, sqz;
  logic [DIST_BITS-1:0]       sq_dist;
  logic                       take;
  logic                       load;

  assign cx = centroid[SAMPLE_BITS-1:0];
  assign cy = centroid[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign cz = centroid[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign dx = (x_in >= cx) ? (x_in - cx) : (cx - x_in);
  assign dy = (y_in >= cy) ? (y_in - cy) : (cy - y_in);
  assign dz = (z_in >= cz) ? (z_in - cz) : (cz - z_in);

  assign sqx = (2*SAMPLE_BITS)'(dx) * (2*SAMPLE_BITS)'(dx);
  assign sqy = (2*SAMPLE_BITS)'(dy) * (2*SAMPLE_BITS)'(dy);
  assign sqz = (2*SAMPLE_BITS)'(dz) * (2*SAMPLE_BITS)'(dz);

  assign sq_dist = DIST_BITS'(sqx) + DIST_BITS'(sqy) + DIST_BITS'(sqz);

  // strict compare keeps the lower index on a tie; the first cell always takes
  assign take = (CELL_IDX == 0) || (sq_dist < best_d_in);

  // bubbles collapse: a cell refills whenever it is empty or moving on
  assign ready_out = !v_r || ready_in;
  assign load      = ready_out && ctl_in.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_out) begin
      v_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func_r     <= ctl_in.func;
      x_r        <= x_in;
      y_r        <= y_in;
      z_r        <= z_in;
      row_r      <= row_in;
      col_r      <= col_in;
      best_d_r   <= take ? sq_dist : best_d_in;
      best_idx_r <= take ? CLASS_BITS'(CELL_IDX) : best_idx_in;
    end
  end

  assign ctl_out      = '{valid: v_r, func: func_r};
  assign x_out        = x_r;
  assign y_out        = y_r;
  assign z_out        = z_r;
  assign row_out      = row_r;
  assign col_out      = col_r;
  assign best_d_out   = best_d_r;
  assign best_idx_out = best_idx_r;

endmodule

[rtl/ncc_count.sv]
// ----------------------------------------------------------------------------
// ncc_count
// Confusion counter bank: RAM with per-entry valid flags, update and output.
// ----------------------------------------------------------------------------
`include "nearest_centroid_confusion_counter_defines.svh"

module ncc_count #(
  parameter int NUM_CLASSES = 6,
  parameter int CLASS_BITS  = 3,
  parameter int COUNT_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ncc_pkg::ncc_ctl_t     ctl_in,
  input  logic [CLASS_BITS-1:0] row_in,
  input  logic [CLASS_BITS-1:0] col_in,
  input  logic [CLASS_BITS-1:0] win_in,
  output logic                  ready_out,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CLASS_BITS-1:0] out_predicted_class,
  output logic [COUNT_BITS-1:0] out_cell_count
);

  localparam int DEPTH     = NUM_CLASSES * NUM_CLASSES;
  localparam int ADDR_BITS = $clog2(DEPTH);

  // incoming address
  logic                  row_ok, col_ok, in_range;
  logic [CLASS_BITS-1:0] col_sel;
  logic [ADDR_BITS-1:0]  addr;
  logic                  rd_en;

  // update stage
  logic                  u_v_r;
  ncc_pkg::func_t        u_func_r;
  logic [CLASS_BITS-1:0] u_win_r;
  logic [ADDR_BITS-1:0]  u_addr_r;
  logic                  u_ok_r;
  logic                  u_move;

  logic [DEPTH-1:0]      cnt_vld_r, cnt_vld_nxt;
  logic                  lw_v_r;
  logic [ADDR_BITS-1:0]  lw_addr_r;
  logic [COUNT_BITS-1:0] lw_data_r;

  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur, inc;
  logic                  ram_we;

  // output register
  logic                  o_v_r;
  logic [CLASS_BITS-1:0] o_pred_r, o_pred_nxt;
  logic [COUNT_BITS-1:0] o_cnt_r, o_cnt_nxt;
  logic                  o_ready;

  assign col_sel = (ctl_in.func == ncc_pkg::FUNC_READ) ? col_in : win_in;
  assign row_ok  = (CLASS_BITS+1)'(row_in) < (CLASS_BITS+1)'(NUM_CLASSES);
  assign col_ok  = (CLASS_BITS+1)'(col_sel) < (CLASS_BITS+1)'(NUM_CLASSES);
  assign in_range = row_ok && col_ok;
  assign addr = in_range ?
                ADDR_BITS'(row_in) * ADDR_BITS'(NUM_CLASSES) + ADDR_BITS'(col_sel) :
                '0;

  assign o_ready   = !o_v_r || !out_stall;
  assign ready_out = !u_v_r || o_ready;
  assign u_move    = u_v_r && o_ready;
  assign rd_en     = ready_out && ctl_in.valid;

  ncc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (u_addr_r),
    .wdata (inc),
    .re    (rd_en),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // a write on the same edge as our read is not seen by the RAM: forward it
  always_comb begin
    cur = '0;
    if (u_ok_r && cnt_vld_r[u_addr_r]) begin
      cur = (lw_v_r && lw_addr_r == u_addr_r) ? lw_data_r : ram_rdata;
    end
  end

  assign inc    = (&cur) ? cur : cur + COUNT_BITS'(1);
  assign ram_we = u_move && u_func_r == ncc_pkg::FUNC_CLASSIFY && u_ok_r;

  always_comb begin
    cnt_vld_nxt = cnt_vld_r;
    o_pred_nxt  = '0;
    o_cnt_nxt   = '0;
    case (u_func_r)
      ncc_pkg::FUNC_CLASSIFY: begin
        o_pred_nxt = u_win_r;
        if (u_ok_r) begin
          o_cnt_nxt = inc;
          cnt_vld_nxt[u_addr_r] = 1'b1;
        end
      end
      ncc_pkg::FUNC_CLEAR: begin
        cnt_vld_nxt = '0;
      end
      ncc_pkg::FUNC_READ: begin
        o_cnt_nxt = cur;
      end
      default: begin
        o_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r     <= 1'b0;
      o_v_r     <= 1'b0;
      lw_v_r    <= 1'b0;
      cnt_vld_r <= '0;
    end else begin
      if (ready_out) begin
        u_v_r <= ctl_in.valid;
      end
      if (o_ready) begin
        o_v_r <= u_v_r;
      end
      if (u_move) begin
        cnt_vld_r <= cnt_vld_nxt;
        if (ram_we) begin
          lw_v_r <= 1'b1;
        end else if (u_func_r == ncc_pkg::FUNC_CLEAR) begin
          lw_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      u_func_r <= ctl_in.func;
      u_win_r  <= win_in;
      u_addr_r <= addr;
      u_ok_r   <= (ctl_in.func == ncc_pkg::FUNC_READ) ? in_range : row_ok;
    end
    if (ram_we) begin
      lw_addr_r <= u_addr_r;
      lw_data_r <= inc;
    end
    if (u_move) begin
      o_pred_r <= o_pred_nxt;
      o_cnt_r  <= o_cnt_nxt;
    end
  end

  assign out_valid           = o_v_r;
  assign out_predicted_class = o_pred_r;
  assign out_cell_count      = o_cnt_r;

  `NCC_ASSERT_NXT(a_clear_drops_all, clk, rst_n, u_move && u_func_r == ncc_pkg::FUNC_CLEAR, cnt_vld_r == '0, "clear left a counter marked valid")
  `NCC_ASSERT_IMP(a_write_nonzero, clk, rst_n, ram_we, inc != '0, "counter write of zero")
  `NCC_ASSERT_IMP(a_fwd_entry_valid, clk, rst_n, lw_v_r, cnt_vld_r[lw_addr_r], "forwarded entry not valid")
  `NCC_ASSERT_IMP(a_write_needs_slot, clk, rst_n, ram_we, u_v_r && o_ready, "counter written without advancing")

endmodule

[rtl/nearest_centroid_confusion_counter.sv]
// ----------------------------------------------------------------------------
// nearest_centroid_confusion_counter
// Nearest-centroid classifier for 3-axis samples with a confusion counter bank.
// ----------------------------------------------------------------------------
// One word is taken per clock when the output side keeps up. A word passes
// through one register in each centroid cell of the distance chain, the
// counter update stage (one RAM read and one write per cycle, with the
// previous write forwarded) and the output register. Empty slots in the chain
// close up, so words are still taken while a result waits. Clear takes a
// single word: the counters carry valid flags that reset and clear drop at
// once, so there is no clearing pass after reset. Centroid registers are
// written through cfg_we / cfg_index / cfg_wdata while the block is idle;
// indexes of NUM_CLASSES and above are ignored.
// ----------------------------------------------------------------------------
module nearest_centroid_confusion_counter #(
  parameter int NUM_CLASSES = 6,
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [$clog2(NUM_CLASSES):0]       cfg_index,
  input  logic [3*SAMPLE_BITS-1:0]           cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [SAMPLE_BITS-1:0]             in_sample_x,
  input  logic [SAMPLE_BITS-1:0]             in_sample_y,
  input  logic [SAMPLE_BITS-1:0]             in_sample_z,
  input  logic [$clog2(NUM_CLASSES)-1:0]     in_true_class,
  input  logic [$clog2(NUM_CLASSES)-1:0]     in_read_column,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(NUM_CLASSES)-1:0]     out_predicted_class,
  output logic [COUNT_BITS-1:0]              out_cell_count
);

  localparam int CLASS_BITS = $clog2(NUM_CLASSES);
  localparam int IDX_BITS   = CLASS_BITS + 1;
  localparam int DIST_BITS  = 2 * SAMPLE_BITS + 2;

  logic [3*SAMPLE_BITS-1:0] center_r [0:NUM_CLASSES-1];

  ncc_pkg::ncc_ctl_t        ctl_s      [0:NUM_CLASSES];
  logic [SAMPLE_BITS-1:0]   x_s        [0:NUM_CLASSES];
  logic [SAMPLE_BITS-1:0]   y_s        [0:NUM_CLASSES];
  logic [SAMPLE_BITS-1:0]   z_s        [0:NUM_CLASSES];
  logic [CLASS_BITS-1:0]    row_s      [0:NUM_CLASSES];
  logic [CLASS_BITS-1:0]    col_s      [0:NUM_CLASSES];
  logic [DIST_BITS-1:0]     best_d_s   [0:NUM_CLASSES];
  logic [CLASS_BITS-1:0]    best_idx_s [0:NUM_CLASSES];
  logic                     ready_s    [0:NUM_CLASSES];

  genvar k;

  generate
    for (k = 0; k < NUM_CLASSES; k++) begin : g_center
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          center_r[k] <= '0;
        end else if (cfg_we && cfg_index == IDX_BITS'(k)) begin
          center_r[k] <= cfg_wdata;
        end
      end
    end
  endgenerate

  assign ctl_s[0]      = '{valid: in_valid, func: in_func};
  assign x_s[0]        = in_sample_x;
  assign y_s[0]        = in_sample_y;
  assign z_s[0]        = in_sample_z;
  assign row_s[0]      = in_true_class;
  assign col_s[0]      = in_read_column;
  assign best_d_s[0]   = '0;
  assign best_idx_s[0] = '0;
  assign in_stall      = !ready_s[0];

  generate
    for (k = 0; k < NUM_CLASSES; k++) begin : g_cell
      ncc_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CLASS_BITS  (CLASS_BITS),
        .DIST_BITS   (DIST_BITS),
        .CELL_IDX    (k)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .centroid     (center_r[k]),
        .ctl_in       (ctl_s[k]),
        .x_in         (x_s[k]),
        .y_in         (y_s[k]),
        .z_in         (z_s[k]),
        .row_in       (row_s[k]),
        .col_in       (col_s[k]),
        .best_d_in    (best_d_s[k]),
        .best_idx_in  (best_idx_s[k]),
        .ready_in     (ready_s[k+1]),
        .ready_out    (ready_s[k]),
        .ctl_out      (ctl_s[k+1]),
        .x_out        (x_s[k+1]),
        .y_out        (y_s[k+1]),
        .z_out        (z_s[k+1]),
        .row_out      (row_s[k+1]),
        .col_out      (col_s[k+1]),
        .best_d_out   (best_d_s[k+1]),
        .best_idx_out (best_idx_s[k+1])
      );
    end
  endgenerate

  ncc_count #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_BITS  (CLASS_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_count (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl_in              (ctl_s[NUM_CLASSES]),
    .row_in              (row_s[NUM_CLASSES]),
    .col_in              (col_s[NUM_CLASSES]),
    .win_in              (best_idx_s[NUM_CLASSES]),
    .ready_out           (ready_s[NUM_CLASSES]),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_class (out_predicted_class),
    .out_cell_count      (out_cell_count)
  );

endmodule
